// ===== hw/rtl/i2a_pkg.sv =====
`timescale 1ns / 1ps
// Package for the integer-to-ASCII formatter: sizes, character codes,
// sequencer state type and the digit glyph function. No dependencies.
package i2a_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_FIELD   = 63;
    localparam int STORE_DEPTH = VALUE_WIDTH + 1;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int FW_W        = 6;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SIGN,
        ST_PAD,
        ST_TXT_RD,
        ST_TXT_OUT
    } state_t;

    // ASCII glyph of one digit, 0-9 then a-f or A-F
    function automatic logic [7:0] digit_glyph(input logic [DIGIT_W-1:0] d,
                                               input logic lower);
        logic [7:0] ch;
        if (d < 4'd10)
        begin
            ch = CHAR_ZERO + {4'd0, d};
        end
        else if (lower)
        begin
            ch = CHAR_LOWER + {4'd0, d} - 8'd10;
        end
        else
        begin
            ch = CHAR_UPPER + {4'd0, d} - 8'd10;
        end
        return ch;
    endfunction

endpackage

// ===== hw/rtl/i2a_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the formatter: valid/ready plus value and format fields.
// Depends on i2a_pkg.
interface i2a_in_if;
    logic                              valid;
    logic                              ready;
    logic [31:0]                       value;
    logic                              signed_mode;
    logic                              show_plus;
    logic [i2a_pkg::RADIX_W-1:0]       radix;
    logic                              lower_digits;
    logic                              left_justify;
    logic [i2a_pkg::FW_W-1:0]          field_width;
    logic [7:0]                        pad_char;

    modport source (output valid, value, signed_mode, show_plus, radix, lower_digits,
                    left_justify, field_width, pad_char, input ready);
    modport sink   (input valid, value, signed_mode, show_plus, radix, lower_digits,
                    left_justify, field_width, pad_char, output ready);
endinterface

// ===== hw/rtl/i2a_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the formatter: one character per beat, last flag.
// No dependencies.
interface i2a_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, out_char, last, input ready);
    modport sink   (input valid, out_char, last, output ready);
endinterface

// ===== hw/rtl/i2a_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 33
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/i2a_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider: VALUE_WIDTH-bit dividend by a radix of 2..16,
// one quotient bit per cycle. Depends on i2a_pkg.
module i2a_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [i2a_pkg::VALUE_WIDTH-1:0]      dividend,
    input  logic [i2a_pkg::RADIX_W-1:0]          divisor,
    output logic [i2a_pkg::VALUE_WIDTH-1:0]      quotient,
    output logic [i2a_pkg::DIGIT_W-1:0]          remainder,
    output logic                                 done
);

    logic [i2a_pkg::VALUE_WIDTH-1:0] q_reg, q_next;
    logic [i2a_pkg::DIGIT_W-1:0]     r_reg, r_next;
    logic [i2a_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [i2a_pkg::RADIX_W-1:0]     trial;
    logic                            ge;

    // partial remainder stays below divisor, so 4 bits hold it
    assign trial = {r_reg, q_reg[i2a_pkg::VALUE_WIDTH-1]};
    assign ge    = (trial >= divisor);

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[i2a_pkg::VALUE_WIDTH-2:0], ge};
            r_next   = ge ? i2a_pkg::DIGIT_W'(trial - divisor)
                          : i2a_pkg::DIGIT_W'(trial);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == i2a_pkg::CNT_W'(i2a_pkg::VALUE_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign done      = done_reg;

endmodule

// ===== hw/rtl/integer_to_ascii_padded.sv =====
`timescale 1ns / 1ps
// integer_to_ascii_padded: integer in, padded ASCII text out, one char a beat; uses i2a_pkg,
// i2a_in_if, i2a_out_if, i2a_ram and i2a_div.
// Sequence: one divider pass per digit, D = digit count (1..VALUE_WIDTH), then the sign write,
// then pad and text chars in field order; each text char is read from the digit RAM first.
// A new item is accepted only once the last char of the previous one is in the output register.
// Reset (rst_n, async, active low) clears sequencer and output valid; digit RAM not cleared.
module integer_to_ascii_padded (
    input  logic      clk,
    input  logic      rst_n,
    i2a_in_if.sink    din,
    i2a_out_if.source dout
);

    i2a_pkg::state_t state_reg, state_next;

    // per-item settings, latched on accept
    logic [i2a_pkg::VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [i2a_pkg::RADIX_W-1:0]     radix_reg, radix_next;
    logic                            lower_reg, lower_next;
    logic                            left_reg, left_next;
    logic [i2a_pkg::FW_W-1:0]        width_reg, width_next;
    logic [7:0]                      pad_char_reg, pad_char_next;
    logic [7:0]                      sign_char_reg, sign_char_next;
    logic                            has_sign_reg, has_sign_next;

    // text length, pad chars left, text chars left
    logic [i2a_pkg::LEN_W-1:0]       len_reg, len_next;
    logic [i2a_pkg::FW_W-1:0]        pad_cnt_reg, pad_cnt_next;
    logic [i2a_pkg::LEN_W-1:0]       txt_idx_reg, txt_idx_next;

    // output register, parts the sequencer from the sink
    logic                            out_valid_reg, out_valid_next;
    logic [7:0]                      out_char_reg, out_char_next;
    logic                            out_last_reg, out_last_next;

    // decoded input beat
    logic [i2a_pkg::VALUE_WIDTH-1:0] raw;
    logic                            neg;
    logic [i2a_pkg::RADIX_W-1:0]     radix_c;
    logic [i2a_pkg::FW_W-1:0]        width_c;
    logic [i2a_pkg::LEN_W-1:0]       len_total;
    logic [i2a_pkg::FW_W-1:0]        pad_total;
    logic                            slot_free;

    // divider hookup
    logic                            div_start;
    logic [i2a_pkg::VALUE_WIDTH-1:0] div_q;
    logic [i2a_pkg::DIGIT_W-1:0]     div_r;
    logic                            div_done;

    // digit store: least significant digit at entry 0, sign on top
    logic                            ram_we;
    logic [i2a_pkg::ADDR_W-1:0]      ram_waddr;
    logic [7:0]                      ram_wdata;
    logic [i2a_pkg::ADDR_W-1:0]      ram_raddr;
    logic [7:0]                      ram_rdata;

    i2a_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (radix_reg),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    i2a_ram #(
        .WIDTH (8),
        .DEPTH (i2a_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign raw = i2a_pkg::VALUE_WIDTH'(din.value);
    assign neg = din.signed_mode & raw[i2a_pkg::VALUE_WIDTH-1];

    // out-of-range radix and field width saturate
    always_comb
    begin
        if (din.radix < i2a_pkg::RADIX_MIN)
        begin
            radix_c = i2a_pkg::RADIX_MIN;
        end
        else if (din.radix > i2a_pkg::RADIX_MAX)
        begin
            radix_c = i2a_pkg::RADIX_MAX;
        end
        else
        begin
            radix_c = din.radix;
        end
        if (din.field_width > i2a_pkg::FW_W'(i2a_pkg::MAX_FIELD))
        begin
            width_c = i2a_pkg::FW_W'(i2a_pkg::MAX_FIELD);
        end
        else
        begin
            width_c = din.field_width;
        end
    end

    // text length once the sign is in; padding fills up to the field width
    assign len_total = len_reg + i2a_pkg::LEN_W'(has_sign_reg);
    assign pad_total = (width_reg > i2a_pkg::FW_W'(len_total))
                     ? (width_reg - i2a_pkg::FW_W'(len_total))
                     : '0;

    assign slot_free = !out_valid_reg || dout.ready;
    assign ram_raddr = i2a_pkg::ADDR_W'(txt_idx_reg - 1'b1);
    assign din.ready = (state_reg == i2a_pkg::ST_IDLE);
    assign div_start = (state_reg == i2a_pkg::ST_DIV_GO);

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        radix_next     = radix_reg;
        lower_next     = lower_reg;
        left_next      = left_reg;
        width_next     = width_reg;
        pad_char_next  = pad_char_reg;
        sign_char_next = sign_char_reg;
        has_sign_next  = has_sign_reg;
        len_next       = len_reg;
        pad_cnt_next   = pad_cnt_reg;
        txt_idx_next   = txt_idx_reg;
        out_valid_next = out_valid_reg && !dout.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = i2a_pkg::ADDR_W'(len_reg);
        ram_wdata      = i2a_pkg::digit_glyph(div_r, lower_reg);

        unique case (state_reg)
            i2a_pkg::ST_IDLE:
            begin
                if (din.valid)
                begin
                    mag_next       = neg ? (~raw + 1'b1) : raw;
                    radix_next     = radix_c;
                    lower_next     = din.lower_digits;
                    left_next      = din.left_justify;
                    width_next     = width_c;
                    pad_char_next  = din.pad_char;
                    sign_char_next = neg ? i2a_pkg::CHAR_MINUS : i2a_pkg::CHAR_PLUS;
                    has_sign_next  = neg || din.show_plus;
                    len_next       = '0;
                    state_next     = i2a_pkg::ST_DIV_GO;
                end
            end

            i2a_pkg::ST_DIV_GO:
            begin
                state_next = i2a_pkg::ST_DIV_WAIT;
            end

            // a zero value runs one pass and yields the single '0' digit
            i2a_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    ram_we     = 1'b1;
                    len_next   = len_reg + 1'b1;
                    mag_next   = div_q;
                    state_next = (div_q == '0) ? i2a_pkg::ST_SIGN : i2a_pkg::ST_DIV_GO;
                end
            end

            i2a_pkg::ST_SIGN:
            begin
                ram_we       = has_sign_reg;
                ram_wdata    = sign_char_reg;
                len_next     = len_total;
                txt_idx_next = len_total;
                pad_cnt_next = pad_total;
                if (!left_reg && pad_total != '0)
                begin
                    state_next = i2a_pkg::ST_PAD;
                end
                else
                begin
                    state_next = i2a_pkg::ST_TXT_RD;
                end
            end

            i2a_pkg::ST_PAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = pad_char_reg;
                    out_last_next  = left_reg && (pad_cnt_reg == 6'd1);
                    pad_cnt_next   = pad_cnt_reg - 1'b1;
                    if (pad_cnt_reg == 6'd1)
                    begin
                        state_next = left_reg ? i2a_pkg::ST_IDLE : i2a_pkg::ST_TXT_RD;
                    end
                end
            end

            i2a_pkg::ST_TXT_RD:
            begin
                state_next = i2a_pkg::ST_TXT_OUT;
            end

            // read address holds while waiting, so read data stays put
            i2a_pkg::ST_TXT_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ram_rdata;
                    out_last_next  = (txt_idx_reg == 6'd1)
                                   && (!left_reg || pad_cnt_reg == '0);
                    txt_idx_next   = txt_idx_reg - 1'b1;
                    if (txt_idx_reg == 6'd1)
                    begin
                        if (left_reg && pad_cnt_reg != '0)
                        begin
                            state_next = i2a_pkg::ST_PAD;
                        end
                        else
                        begin
                            state_next = i2a_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = i2a_pkg::ST_TXT_RD;
                    end
                end
            end

            default:
            begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i2a_pkg::ST_IDLE;
            len_reg       <= '0;
            pad_cnt_reg   <= '0;
            txt_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            mag_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pad_cnt_reg   <= pad_cnt_next;
            txt_idx_reg   <= txt_idx_next;
            out_valid_reg <= out_valid_next;
            mag_reg       <= mag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg     <= radix_next;
        lower_reg     <= lower_next;
        left_reg      <= left_next;
        width_reg     <= width_next;
        pad_char_reg  <= pad_char_next;
        sign_char_reg <= sign_char_next;
        has_sign_reg  <= has_sign_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

    assign dout.valid    = out_valid_reg;
    assign dout.out_char = out_char_reg;
    assign dout.last     = out_last_reg;

endmodule

// ===== sim/integer_to_ascii_padded_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for integer_to_ascii_padded: predicts the padded text of each
// accepted request and compares the output channel beat by beat.
// Depends on i2a_in_if and i2a_out_if.
module i2a_text_checker (
    input  logic clk,
    input  logic rst_n,
    i2a_in_if    din,
    i2a_out_if   dout,
    output int   fail_count,
    output int   chars_pending
);

    localparam logic [7:0] MINUS_CH = 8'h2d;
    localparam logic [7:0] PLUS_CH  = 8'h2b;
    localparam logic [4:0] BASE_LO  = 5'd2;
    localparam logic [4:0] BASE_HI  = 5'd16;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    char_beat_t char_q[$];
    char_beat_t exp_beat;
    int         mismatches;

    assign fail_count = mismatches;

    // Appends the characters of one request to char_q, in emit order
    task automatic predict_text(input logic [31:0] value, input logic sgn,
                                input logic plus, input logic [4:0] radix,
                                input logic lower, input logic left,
                                input logic [5:0] width, input logic [7:0] pad);
        string       glyphs;
        logic [31:0] mag;
        logic [31:0] base;
        logic        neg;
        logic [7:0]  txt[$];
        logic [7:0]  seq[$];
        int          npad;
        char_beat_t  b;
        if (lower)
            glyphs = "0123456789abcdef";
        else
            glyphs = "0123456789ABCDEF";
        base = 32'((radix < BASE_LO) ? BASE_LO : (radix > BASE_HI) ? BASE_HI : radix);
        neg  = sgn && value[31];
        mag  = neg ? (~value + 32'd1) : value;
        // digits come out least significant first and are pushed to the front
        if (mag == 32'd0)
            txt.push_front(glyphs[0]);
        while (mag != 32'd0)
        begin
            txt.push_front(glyphs[mag % base]);
            mag = mag / base;
        end
        if (neg)
            txt.push_front(MINUS_CH);
        else if (plus)
            txt.push_front(PLUS_CH);
        npad = (int'(width) > txt.size()) ? int'(width) - txt.size() : 0;
        if (left)
        begin
            seq = txt;
            repeat (npad) seq.push_back(pad);
        end
        else
        begin
            repeat (npad) seq.push_back(pad);
            foreach (txt[i]) seq.push_back(txt[i]);
        end
        foreach (seq[i])
        begin
            b.ch   = seq[i];
            b.last = (i == seq.size() - 1);
            char_q.push_back(b);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_q.delete();
            mismatches    = 0;
            chars_pending <= 0;
        end
        else
        begin
            // output first: a beat leaving now belongs to an earlier request
            if (dout.valid && dout.ready)
            begin
                if (char_q.size() == 0)
                begin
                    $error("out_char: unexpected beat, expected none, got %h", dout.out_char);
                    mismatches++;
                end
                else
                begin
                    exp_beat = char_q.pop_front();
                    if (dout.out_char !== exp_beat.ch)
                    begin
                        $error("out_char: expected %h, got %h", exp_beat.ch, dout.out_char);
                        mismatches++;
                    end
                    if (dout.last !== exp_beat.last)
                    begin
                        $error("last: expected %b, got %b", exp_beat.last, dout.last);
                        mismatches++;
                    end
                end
            end
            if (din.valid && din.ready)
                predict_text(din.value, din.signed_mode, din.show_plus, din.radix,
                             din.lower_digits, din.left_justify, din.field_width,
                             din.pad_char);
            chars_pending <= char_q.size();
        end
    end

endmodule

// ===== sim/integer_to_ascii_padded_tb.sv =====
`timescale 1ns / 1ps
// Top of the integer_to_ascii_padded testbench: clock, reset, request and
// output-ready drivers, verdict. Depends on i2a_pkg, i2a_in_if, i2a_out_if,
// i2a_text_checker and the block itself.
module integer_to_ascii_padded_tb;

    // Phase sizes of the random part (about 350 requests in all)
    localparam int RAND_A     = 150;
    localparam int BURST      = 50;   // both sides never idle
    localparam int PRESS      = 20;   // offered while the output is held off
    localparam int RAND_B     = 130;
    // A radix-2 request of 32 digits needs one divider pass per digit before its first char;
    // the hold must outlast that so the block fills and drops din.ready.
    localparam int LONG_HOLD  = 1500;
    localparam int DRAIN_WAIT = 1500;

    typedef struct {
        logic [31:0]                 value;
        logic                        sgn;
        logic                        plus;
        logic [i2a_pkg::RADIX_W-1:0] radix;
        logic                        lower;
        logic                        left;
        logic [i2a_pkg::FW_W-1:0]    width;
        logic [7:0]                  pad;
    } fmt_req_t;

    logic     clk;
    logic     rst_n;
    int       fail_count;
    int       chars_pending;
    bit       no_idle;    // both sides run without gaps
    bit       hold_req;   // asks the output side for one long hold-off
    fmt_req_t dir_q[$];

    i2a_in_if  din_ch();
    i2a_out_if dout_ch();

    integer_to_ascii_padded i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_ch),
        .dout  (dout_ch)
    );

    i2a_text_checker i_text_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .din           (din_ch),
        .dout          (dout_ch),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic fmt_req_t make_req(input logic [31:0] value, input logic sgn,
                                          input logic plus, input logic [4:0] radix,
                                          input logic lower, input logic left,
                                          input logic [5:0] width, input logic [7:0] pad);
        fmt_req_t r;
        r.value = value;
        r.sgn   = sgn;
        r.plus  = plus;
        r.radix = radix;
        r.lower = lower;
        r.left  = left;
        r.width = width;
        r.pad   = pad;
        return r;
    endfunction

    // Random request. Values lean toward short digit strings and edge values;
    // radix is now and then taken from the whole 5-bit range to hit saturation.
    function automatic fmt_req_t rand_req();
        fmt_req_t    r;
        int unsigned nbits;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       r.value = 32'h0000_0000;
                    1:       r.value = 32'hffff_ffff;
                    2:       r.value = 32'h8000_0000;
                    3:       r.value = 32'h7fff_ffff;
                    default: r.value = 32'h0000_0001;
                endcase
            end
            1, 2:    r.value = $urandom_range(0, 255);
            3, 4:
            begin
                nbits   = $urandom_range(1, 31);
                r.value = $urandom & ((32'd1 << nbits) - 32'd1);
            end
            default: r.value = $urandom;
        endcase
        r.sgn   = 1'($urandom_range(0, 1));
        r.plus  = 1'($urandom_range(0, 1));
        r.lower = 1'($urandom_range(0, 1));
        r.left  = 1'($urandom_range(0, 1));
        r.radix = i2a_pkg::RADIX_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                                : $urandom_range(2, 16));
        r.width = i2a_pkg::FW_W'(($urandom_range(0, 4) == 0) ? $urandom_range(25, 63)
                                                             : $urandom_range(0, 24));
        r.pad   = 8'($urandom_range(0, 255));
        return r;
    endfunction

    // One request beat. valid is lowered only when a gap is wanted, so
    // back-to-back beats keep it high without a second assignment per step.
    task automatic send_req(input fmt_req_t r);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            din_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_ch.valid        <= 1'b1;
        din_ch.value        <= r.value;
        din_ch.signed_mode  <= r.sgn;
        din_ch.show_plus    <= r.plus;
        din_ch.radix        <= r.radix;
        din_ch.lower_digits <= r.lower;
        din_ch.left_justify <= r.left;
        din_ch.field_width  <= r.width;
        din_ch.pad_char     <= r.pad;
        do @(posedge clk); while (!din_ch.ready);
    endtask

    // Stop offering and wait until every predicted char has come out
    task automatic wait_drained();
        din_ch.valid <= 1'b0;
        do @(posedge clk); while (chars_pending != 0);
    endtask

    // Output side: random stalls, no-gap stretches, one long counted hold
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        dout_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                dout_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (no_idle)
            begin
                dout_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                dout_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                dout_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Request side and verdict
    initial
    begin
        rst_n    = 1'b0;
        no_idle  = 1'b0;
        hold_req = 1'b0;
        din_ch.valid        <= 1'b0;
        din_ch.value        <= '0;
        din_ch.signed_mode  <= 1'b0;
        din_ch.show_plus    <= 1'b0;
        din_ch.radix        <= '0;
        din_ch.lower_digits <= 1'b0;
        din_ch.left_justify <= 1'b0;
        din_ch.field_width  <= '0;
        din_ch.pad_char     <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: value    sgn   plus  radix  lower left  width pad
        // zero gives a lone '0', with and without a plus sign
        dir_q.push_back(make_req(32'h0000_0000, 1'b0, 1'b0, 5'd10, 1'b0, 1'b0, 6'd0,  8'h20));
        dir_q.push_back(make_req(32'h0000_0000, 1'b1, 1'b1, 5'd10, 1'b0, 1'b0, 6'd0,  8'h20));
        // all ones: 32 binary digits unsigned, -1 signed
        dir_q.push_back(make_req(32'hffff_ffff, 1'b0, 1'b0, 5'd2,  1'b0, 1'b0, 6'd0,  8'h20));
        dir_q.push_back(make_req(32'hffff_ffff, 1'b1, 1'b0, 5'd10, 1'b0, 1'b0, 6'd0,  8'h20));
        // most negative value, decimal and binary (33 chars of text)
        dir_q.push_back(make_req(32'h8000_0000, 1'b1, 1'b0, 5'd10, 1'b0, 1'b0, 6'd0,  8'h20));
        dir_q.push_back(make_req(32'h8000_0000, 1'b1, 1'b1, 5'd2,  1'b0, 1'b1, 6'd40, 8'h2e));
        // largest positive with plus; plus on an unsigned value with MSB set
        dir_q.push_back(make_req(32'h7fff_ffff, 1'b1, 1'b1, 5'd16, 1'b0, 1'b0, 6'd0,  8'h20));
        dir_q.push_back(make_req(32'h8000_0001, 1'b0, 1'b1, 5'd16, 1'b0, 1'b0, 6'd0,  8'h20));
        // hex digits in both cases
        dir_q.push_back(make_req(32'hdead_beef, 1'b0, 1'b0, 5'd16, 1'b1, 1'b0, 6'd0,  8'h20));
        dir_q.push_back(make_req(32'hdead_beef, 1'b0, 1'b0, 5'd16, 1'b0, 1'b0, 6'd0,  8'h20));
        // radix out of range saturates: 0 and 1 to base 2, 17 and 31 to base 16
        dir_q.push_back(make_req(32'h0000_00a5, 1'b0, 1'b0, 5'd0,  1'b0, 1'b0, 6'd0,  8'h20));
        dir_q.push_back(make_req(32'h0000_00a5, 1'b0, 1'b0, 5'd1,  1'b0, 1'b0, 6'd0,  8'h20));
        dir_q.push_back(make_req(32'h0000_abcd, 1'b0, 1'b0, 5'd17, 1'b1, 1'b0, 6'd0,  8'h20));
        dir_q.push_back(make_req(32'h0000_abcd, 1'b0, 1'b0, 5'd31, 1'b0, 1'b0, 6'd0,  8'h20));
        // widest field, both justifications
        dir_q.push_back(make_req(32'd42,        1'b0, 1'b0, 5'd10, 1'b0, 1'b0, 6'd63, 8'h2a));
        dir_q.push_back(make_req(32'd42,        1'b0, 1'b1, 5'd10, 1'b0, 1'b1, 6'd63, 8'h20));
        // negative, right justified (pad goes ahead of the sign) and left justified
        dir_q.push_back(make_req(32'hffff_ff85, 1'b1, 1'b0, 5'd10, 1'b0, 1'b0, 6'd10, 8'h30));
        dir_q.push_back(make_req(32'hffff_ff85, 1'b1, 1'b1, 5'd8,  1'b0, 1'b1, 6'd12, 8'h2e));
        // text longer than the field, and exactly as long
        dir_q.push_back(make_req(32'hffff_ffff, 1'b0, 1'b0, 5'd2,  1'b0, 1'b1, 6'd5,  8'h2d));
        dir_q.push_back(make_req(32'd12345,     1'b0, 1'b0, 5'd10, 1'b0, 1'b0, 6'd5,  8'h2d));
        // odd bases and extreme pad bytes
        dir_q.push_back(make_req(32'h1234_5678, 1'b0, 1'b0, 5'd3,  1'b0, 1'b0, 6'd25, 8'h00));
        dir_q.push_back(make_req(32'h1234_5678, 1'b1, 1'b1, 5'd7,  1'b1, 1'b1, 6'd20, 8'hff));
        dir_q.push_back(make_req(32'h0765_4321, 1'b0, 1'b1, 5'd8,  1'b0, 1'b0, 6'd15, 8'h5f));
        foreach (dir_q[i]) send_req(dir_q[i]);

        for (int i = 0; i < RAND_A; i++)
            send_req(rand_req());

        // back to back on both sides
        no_idle = 1'b1;
        for (int i = 0; i < BURST; i++)
            send_req(rand_req());

        // output held off while requests keep coming: input must stall
        hold_req = 1'b1;
        for (int i = 0; i < PRESS; i++)
            send_req(rand_req());

        // sender pauses until everything has come out
        wait_drained();
        no_idle = 1'b0;

        for (int i = 0; i < RAND_B; i++)
            send_req(rand_req());

        wait_drained();
        // extra beats after the last expected one would show up here
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop for a run that hangs
    initial
    begin
        #(60_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
